// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ON_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: property failed");

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER_ON_CLK(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/lfpr_pkg.sv =====
`default_nettype none
package lfpr_pkg;

  localparam int BUFFER_DEPTH_DEF = 512;
  localparam int MAX_SCHEMA_LEN   = 32;
  localparam int WPOS_W           = 9;

  localparam logic [7:0]  START_RESET    = 8'h7E;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  // register indexes (word address)
  localparam logic [2:0] REG_START_BYTE = 3'd0;
  localparam logic [2:0] REG_CRC_SEED   = 3'd1;
  localparam logic [2:0] REG_SOURCE_MIN = 3'd2;
  localparam logic [2:0] REG_SOURCE_MAX = 3'd3;
  localparam logic [2:0] REG_DEST_MIN   = 3'd4;
  localparam logic [2:0] REG_DEST_MAX   = 3'd5;

  typedef enum logic [1:0] {
    CMD_RECV    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_START         = 3'd1,
    EV_START_DROP    = 3'd2,
    EV_GUARD         = 3'd3,
    EV_GUARD_RESTART = 3'd4,
    EV_CRC_BAD       = 3'd5,
    EV_GOOD          = 3'd6,
    EV_NO_PACKET     = 3'd7
  } ev_t;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SRC     = 4'd1,
    PH_DEST    = 4'd2,
    PH_SLEN    = 4'd3,
    PH_SCHEMA  = 4'd4,
    PH_PLEN    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRCHI   = 4'd7,
    PH_CRCLO   = 4'd8
  } phase_t;

  // CRC-16-CCITT, MSB first, one byte folded in
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/length_framed_packet_receiver_crc16.sv =====
// Length-framed packet receiver with CRC-16-CCITT check. Each input transfer
// carries a command in s_tuser: receive a link byte, read a stored body byte
// of the ready packet, or release it. Every command yields exactly one result
// transfer with an event code in m_tuser and the ready-packet summary plus
// read data in m_tdata. The parser, CRC update and body buffer write take one
// pass per byte, so one item is accepted every cycle while results drain;
// each result goes through the result stage, with the registered read of the
// single-port body RAM, and then the output register. The body RAM is not
// cleared after reset: reading an offset never written since reset returns
// undefined data. Configuration registers (APB, word addresses 0..5) may only
// be written while no transfer is in flight.
`default_nettype none
`include "assert_macros.svh"
module length_framed_packet_receiver_crc16 #(
  parameter int BUFFER_DEPTH = lfpr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // command stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // data_byte[7:0], read_index[16:8], zero
  input  wire logic [1:0]  s_tuser,  // command[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,  // packet_ready[0], src_addr[8:1],
                                     // dest_addr[16:9], schema_count[22:17],
                                     // payload_count[30:23],
                                     // payload_start[39:31], read_data[47:40]
  output logic      [2:0]  m_tuser   // event_res[2:0]
);
  import lfpr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  // configuration
  logic [7:0]  start_byte, source_min, source_max, dest_min, dest_max;
  logic [15:0] crc_seed;
  logic        cfg_wr;

  // parser state
  phase_t      phase, phase_next;
  logic [WPOS_W-1:0] write_pos, wpos_next;
  logic [7:0]  bytes_left, left_next;
  logic [5:0]  schema_size, schema_next;
  logic [7:0]  payload_size, psize_next;
  logic [WPOS_W-1:0] payload_base, pbase_next;
  logic [7:0]  crc_hi, crc_hi_next;
  logic [15:0] running_crc, crc_next;
  logic        ready_flag, ready_next;
  logic [7:0]  src_reg, src_next, dest_reg, dest_next;

  // body buffer
  logic [7:0]  mem [BUFFER_DEPTH];
  logic [7:0]  rd_q;
  logic        store, wr_en, rd_grant;
  logic [AW-1:0] wr_addr, rd_addr;

  // stage and output registers
  logic        in_acc, p_valid, p_move;
  ev_t         ev, p_ev, out_ev;
  logic        p_ready, p_rd_en;
  logic [7:0]  p_src, p_dest, p_plen;
  logic [5:0]  p_schema;
  logic [WPOS_W-1:0] p_pbase;
  logic [47:0] out_tdata;
  logic        out_valid;

  logic [7:0]  v;
  logic [WPOS_W-1:0] idx;
  logic        guard, examine;

  assign v   = s_tdata[7:0];
  assign idx = s_tdata[16:8];

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
      crc_seed   <= CRC_SEED_RESET;
      source_min <= 8'h00;
      source_max <= 8'hFF;
      dest_min   <= 8'h00;
      dest_max   <= 8'hFF;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_START_BYTE: start_byte <= pwdata[7:0];
        REG_CRC_SEED:   crc_seed   <= pwdata[15:0];
        REG_SOURCE_MIN: source_min <= pwdata[7:0];
        REG_SOURCE_MAX: source_max <= pwdata[7:0];
        REG_DEST_MIN:   dest_min   <= pwdata[7:0];
        REG_DEST_MAX:   dest_max   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START_BYTE: prdata = {24'h0, start_byte};
      REG_CRC_SEED:   prdata = {16'h0, crc_seed};
      REG_SOURCE_MIN: prdata = {24'h0, source_min};
      REG_SOURCE_MAX: prdata = {24'h0, source_max};
      REG_DEST_MIN:   prdata = {24'h0, dest_min};
      REG_DEST_MAX:   prdata = {24'h0, dest_max};
      default:        prdata = 32'h0;
    endcase
  end

  // ---------------- handshake ----------------
  assign p_move   = p_valid && (!out_valid || m_tready);
  assign s_tready = !p_valid || p_move;
  assign in_acc   = s_tvalid && s_tready;

  // ---------------- parser ----------------
  always_comb begin
    phase_next  = phase;
    wpos_next   = write_pos;
    left_next   = bytes_left;
    schema_next = schema_size;
    psize_next  = payload_size;
    pbase_next  = payload_base;
    crc_hi_next = crc_hi;
    crc_next    = running_crc;
    ready_next  = ready_flag;
    src_next    = src_reg;
    dest_next   = dest_reg;
    ev          = EV_NONE;
    store       = 1'b0;
    guard       = 1'b0;
    examine     = 1'b0;
    rd_grant    = 1'b0;

    case (cmd_t'(s_tuser))
      CMD_RECV: begin
        case (phase)
          PH_HUNT: examine = 1'b1;
          PH_SRC: begin
            if (v < source_min || v > source_max) begin
              guard = 1'b1;
            end else begin
              store      = 1'b1;
              src_next   = v;
              phase_next = PH_DEST;
            end
          end
          PH_DEST: begin
            if (v < dest_min || v > dest_max) begin
              guard = 1'b1;
            end else begin
              store      = 1'b1;
              dest_next  = v;
              phase_next = PH_SLEN;
            end
          end
          PH_SLEN: begin
            if (32'(v) > MAX_SCHEMA_LEN) begin
              guard = 1'b1;
            end else begin
              store       = 1'b1;
              schema_next = v[5:0];
              left_next   = v;
              phase_next  = (v == 8'h00) ? PH_PLEN : PH_SCHEMA;
            end
          end
          PH_SCHEMA: begin
            store     = 1'b1;
            left_next = bytes_left - 8'd1;
            if (left_next == 8'h00) begin
              phase_next = PH_PLEN;
            end
          end
          PH_PLEN: begin
            store      = 1'b1;
            psize_next = v;
            pbase_next = write_pos + 1'b1;
            left_next  = v;
            phase_next = (v == 8'h00) ? PH_CRCHI : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            store     = 1'b1;
            left_next = bytes_left - 8'd1;
            if (left_next == 8'h00) begin
              phase_next = PH_CRCHI;
            end
          end
          PH_CRCHI: begin
            crc_hi_next = v;
            phase_next  = PH_CRCLO;
          end
          PH_CRCLO: begin
            phase_next = PH_HUNT;
            if ({crc_hi, v} == running_crc) begin
              ready_next = 1'b1;
              ev         = EV_GOOD;
            end else begin
              ev = EV_CRC_BAD;
            end
          end
          default: phase_next = PH_HUNT;
        endcase

        if (store) begin
          wpos_next = write_pos + 1'b1;
          crc_next  = crc16_byte(running_crc, v);
        end

        // a byte that fails a guard is examined again as a start byte
        examine = examine || guard;
        if (examine) begin
          if (v == start_byte) begin
            ev         = guard ? EV_GUARD_RESTART : (ready_flag ? EV_START_DROP : EV_START);
            ready_next = 1'b0;
            wpos_next  = '0;
            crc_next   = crc_seed;
            phase_next = PH_SRC;
          end else begin
            ev         = guard ? EV_GUARD : EV_NONE;
            phase_next = PH_HUNT;
          end
        end
      end
      CMD_READ: begin
        if (!ready_flag) begin
          ev = EV_NO_PACKET;
        end else begin
          rd_grant = 32'(idx) < BUFFER_DEPTH;
        end
      end
      CMD_RELEASE: begin
        if (!ready_flag) begin
          ev = EV_NO_PACKET;
        end
        ready_next = 1'b0;
      end
      default: ;
    endcase
  end

  assign wr_en   = in_acc && store && (32'(write_pos) < BUFFER_DEPTH);
  assign wr_addr = AW'(write_pos);
  assign rd_addr = AW'(idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && rd_grant) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      write_pos    <= '0;
      bytes_left   <= '0;
      schema_size  <= '0;
      payload_size <= '0;
      payload_base <= '0;
      crc_hi       <= '0;
      running_crc  <= CRC_SEED_RESET;
      ready_flag   <= 1'b0;
    end else if (in_acc) begin
      phase        <= phase_next;
      write_pos    <= wpos_next;
      bytes_left   <= left_next;
      schema_size  <= schema_next;
      payload_size <= psize_next;
      payload_base <= pbase_next;
      crc_hi       <= crc_hi_next;
      running_crc  <= crc_next;
      ready_flag   <= ready_next;
    end
  end

  // first two body bytes kept beside the RAM for the packet summary
  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_reg  <= src_next;
      dest_reg <= dest_next;
    end
  end

  // ---------------- result stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_acc) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_ev     <= ev;
      p_ready  <= ready_next;
      p_rd_en  <= rd_grant;
      p_src    <= ready_next ? src_next : 8'h00;
      p_dest   <= ready_next ? dest_next : 8'h00;
      p_schema <= ready_next ? schema_next : 6'h00;
      p_plen   <= ready_next ? psize_next : 8'h00;
      p_pbase  <= ready_next ? pbase_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      out_ev    <= p_ev;
      out_tdata <= {(p_rd_en ? rd_q : 8'h00), p_pbase, p_plen, p_schema,
                    p_dest, p_src, p_ready};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_tdata;
  assign m_tuser  = out_ev;

  // ---------------- assertions ----------------
  `ASSERT_ON_CLK(a_ready_only_in_hunt, clk, rst, ready_flag |-> phase == PH_HUNT)
  `ASSERT_ON_CLK(a_good_sets_ready, clk, rst, m_tvalid && out_ev == EV_GOOD |-> m_tdata[0])
  `ASSERT_ON_CLK(a_idle_summary_zero, clk, rst, m_tvalid && !m_tdata[0] |-> m_tdata[39:1] == '0)
  `ASSERT_NEVER_ON_CLK(a_stall_needs_full_stage, clk, rst, !s_tready && !p_valid)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import lfpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 330;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    ev_t        ev;
    logic       ready;
    logic [7:0] src;
    logic [7:0] dst;
    logic [5:0] schema;
    logic [7:0] payload;
    logic [8:0] pstart;
    logic [7:0] rdata;
  } rx_result_t;

  // Tracks the receiver state and the results it must produce, in order.
  class frame_scoreboard;
    logic [7:0]  start_val, src_lo, src_hi, dst_lo, dst_hi;
    logic [15:0] seed;
    phase_t      ph;
    logic [8:0]  wpos;
    logic [7:0]  remaining;
    logic [5:0]  schema_cnt;
    logic [7:0]  payload_cnt;
    logic [8:0]  payload_ofs;
    logic [7:0]  crc_hi;
    logic [15:0] crc;
    bit          ready;
    logic [7:0]  body [BUFFER_DEPTH_DEF];
    bit          body_valid [BUFFER_DEPTH_DEF];
    rx_result_t  pending_results [$];
    int          errors;

    function new();
      start_val = START_RESET;
      seed = CRC_SEED_RESET;
      src_lo = 8'h00;
      src_hi = 8'hFF;
      dst_lo = 8'h00;
      dst_hi = 8'hFF;
      ph = PH_HUNT;
      wpos = '0;
      remaining = '0;
      schema_cnt = '0;
      payload_cnt = '0;
      payload_ofs = '0;
      crc_hi = '0;
      crc = CRC_SEED_RESET;
      ready = 1'b0;
      errors = 0;
      foreach (body_valid[i]) body_valid[i] = 1'b0;
    endfunction

    // CCITT, MSB first: feedback is the top CRC bit against the next data bit
    static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void set_reg(logic [2:0] r, logic [31:0] v);
      case (r)
        REG_START_BYTE: start_val = v[7:0];
        REG_CRC_SEED:   seed = v[15:0];
        REG_SOURCE_MIN: src_lo = v[7:0];
        REG_SOURCE_MAX: src_hi = v[7:0];
        REG_DEST_MIN:   dst_lo = v[7:0];
        REG_DEST_MAX:   dst_hi = v[7:0];
        default: ;
      endcase
    endfunction

    function void store(logic [7:0] b);
      body[wpos] = b;
      body_valid[wpos] = 1'b1;
      wpos = wpos + 9'd1;
      crc = crc_fold(crc, b);
    endfunction

    function ev_t hunt_start(logic [7:0] b, bit after_guard);
      ev_t ev;
      if (b != start_val) return after_guard ? EV_GUARD : EV_NONE;
      if (after_guard) ev = EV_GUARD_RESTART;
      else ev = ready ? EV_START_DROP : EV_START;
      ready = 1'b0;
      wpos = '0;
      crc = seed;
      ph = PH_SRC;
      return ev;
    endfunction

    function ev_t parse_byte(logic [7:0] b);
      case (ph)
        PH_HUNT: return hunt_start(b, 1'b0);
        PH_SRC: begin
          if (b >= src_lo && b <= src_hi) begin
            store(b);
            ph = PH_DEST;
            return EV_NONE;
          end
        end
        PH_DEST: begin
          if (b >= dst_lo && b <= dst_hi) begin
            store(b);
            ph = PH_SLEN;
            return EV_NONE;
          end
        end
        PH_SLEN: begin
          if (b <= MAX_SCHEMA_LEN) begin
            schema_cnt = b[5:0];
            store(b);
            remaining = b;
            ph = (b == 8'd0) ? PH_PLEN : PH_SCHEMA;
            return EV_NONE;
          end
        end
        PH_SCHEMA: begin
          store(b);
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) ph = PH_PLEN;
          return EV_NONE;
        end
        PH_PLEN: begin
          payload_cnt = b;
          store(b);
          payload_ofs = wpos;
          remaining = b;
          ph = (b == 8'd0) ? PH_CRCHI : PH_PAYLOAD;
          return EV_NONE;
        end
        PH_PAYLOAD: begin
          store(b);
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) ph = PH_CRCHI;
          return EV_NONE;
        end
        PH_CRCHI: begin
          crc_hi = b;
          ph = PH_CRCLO;
          return EV_NONE;
        end
        PH_CRCLO: begin
          ph = PH_HUNT;
          if ({crc_hi, b} == crc) begin
            ready = 1'b1;
            return EV_GOOD;
          end
          return EV_CRC_BAD;
        end
        default: begin
          ph = PH_HUNT;
          return EV_NONE;
        end
      endcase
      // guard failed: the same byte may open a new frame
      ph = PH_HUNT;
      return hunt_start(b, 1'b1);
    endfunction

    function void note_input(logic [1:0] c, logic [7:0] d, logic [8:0] ix);
      rx_result_t r;
      r.ev = EV_NONE;
      r.rdata = 8'h00;
      case (c)
        CMD_RECV: r.ev = parse_byte(d);
        CMD_READ: begin
          if (!ready) r.ev = EV_NO_PACKET;
          else r.rdata = body[ix];
        end
        CMD_RELEASE: begin
          if (!ready) r.ev = EV_NO_PACKET;
          ready = 1'b0;
        end
        default: ;
      endcase
      r.ready = ready;
      r.src = ready ? body[0] : 8'h00;
      r.dst = ready ? body[1] : 8'h00;
      r.schema = ready ? schema_cnt : 6'd0;
      r.payload = ready ? payload_cnt : 8'h00;
      r.pstart = ready ? payload_ofs : 9'd0;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(logic [2:0] ev, logic [47:0] d);
      rx_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, event_res", 48'(ev), 48'(0));
        return;
      end
      want = pending_results.pop_front();
      if (ev !== want.ev) report_mismatch("event_res", 48'(ev), 48'(want.ev));
      if (d[0] !== want.ready) report_mismatch("packet_ready", 48'(d[0]), 48'(want.ready));
      if (d[8:1] !== want.src) report_mismatch("src_addr", 48'(d[8:1]), 48'(want.src));
      if (d[16:9] !== want.dst) report_mismatch("dest_addr", 48'(d[16:9]), 48'(want.dst));
      if (d[22:17] !== want.schema)
        report_mismatch("schema_count", 48'(d[22:17]), 48'(want.schema));
      if (d[30:23] !== want.payload)
        report_mismatch("payload_count", 48'(d[30:23]), 48'(want.payload));
      if (d[39:31] !== want.pstart)
        report_mismatch("payload_start", 48'(d[39:31]), 48'(want.pstart));
      if (d[47:40] !== want.rdata)
        report_mismatch("read_data", 48'(d[47:40]), 48'(want.rdata));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // data_byte[7:0], read_index[16:8], zero
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // packet_ready, src, dest, schema, payload, start, read_data
  logic [2:0]  m_tuser;        // event_res[2:0]

  frame_scoreboard frames = new;
  int send_idle = 31;
  int recv_idle = 56;
  int items_sent = 0;
  int cycle_count = 0;

  length_framed_packet_receiver_crc16 dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) frames.check_result(m_tuser, m_tdata);
    m_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  task automatic drive_item(input logic [1:0] c, input logic [7:0] d, input logic [8:0] ix);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {7'd0, ix, d};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames.note_input(c, d, ix);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_item(CMD_RECV, b, 9'($urandom_range(511)));
  endtask

  task automatic apb_write(input logic [2:0] r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    frames.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] sb, input logic [15:0] sd,
                           input logic [7:0] slo, shi, dlo, dhi);
    apb_write(REG_START_BYTE, {24'd0, sb});
    apb_write(REG_CRC_SEED, {16'd0, sd});
    apb_write(REG_SOURCE_MIN, {24'd0, slo});
    apb_write(REG_SOURCE_MAX, {24'd0, shi});
    apb_write(REG_DEST_MIN, {24'd0, dlo});
    apb_write(REG_DEST_MAX, {24'd0, dhi});
  endtask

  // block must be idle before a register write
  task automatic drain();
    s_tvalid <= 1'b0;
    while (frames.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] src, dst, slen, plen, input bit crc_ok);
    logic [7:0]  body_q [$];
    logic [15:0] fcs;
    int          n_schema;
    n_schema = (slen <= MAX_SCHEMA_LEN) ? slen : 2;
    body_q.push_back(src);
    body_q.push_back(dst);
    body_q.push_back(slen);
    repeat (n_schema) body_q.push_back(8'($urandom_range(255)));
    body_q.push_back(plen);
    repeat (plen) body_q.push_back(8'($urandom_range(255)));
    fcs = frames.seed;
    foreach (body_q[i]) fcs = frame_scoreboard::crc_fold(fcs, body_q[i]);
    if (!crc_ok) fcs = fcs ^ 16'(1 + $urandom_range(16'hFFFE));
    send_byte(frames.start_val);
    foreach (body_q[i]) send_byte(body_q[i]);
    send_byte(fcs[15:8]);
    send_byte(fcs[7:0]);
  endtask

  // only offsets written since reset may be read while a packet is held
  function automatic logic [8:0] pick_read_index();
    logic [8:0] ix;
    if (!frames.ready) return 9'($urandom_range(511));
    if ($urandom_range(3) != 0) return 9'($urandom_range(frames.wpos - 9'd1));
    repeat (8) begin
      ix = 9'($urandom_range(511));
      if (frames.body_valid[ix]) return ix;
    end
    return 9'd0;
  endfunction

  function automatic logic [7:0] pick_addr(input logic [7:0] lo, hi);
    if ($urandom_range(99) < 8 || lo > hi) return 8'($urandom_range(255));
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic read_some();
    repeat ($urandom_range(4)) drive_item(CMD_READ, 8'($urandom_range(255)), pick_read_index());
    if ($urandom_range(9) < 7) drive_item(CMD_RELEASE, 8'($urandom_range(255)),
                                          9'($urandom_range(511)));
  endtask

  task automatic random_action();
    int          sel;
    int          r;
    logic [7:0]  slen;
    logic [7:0]  plen;
    sel = $urandom_range(99);
    if (sel < 60) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // largest bodies reach the upper half of the buffer
        slen = 8'($urandom_range(32, 20));
        plen = 8'($urandom_range(255, 230));
      end else begin
        if (r < 13) slen = 8'($urandom_range(255, 33));
        else if (r < 18) slen = 8'd32;
        else if (r < 80) slen = 8'($urandom_range(6));
        else slen = 8'($urandom_range(32, 7));
        plen = ($urandom_range(99) < 75) ? 8'($urandom_range(12)) : 8'($urandom_range(64, 13));
      end
      send_frame(pick_addr(frames.src_lo, frames.src_hi), pick_addr(frames.dst_lo, frames.dst_hi),
                 slen, plen, $urandom_range(99) < 85);
      if (frames.ready) read_some();
    end else if (sel < 75) begin
      repeat ($urandom_range(6, 1))
        send_byte(($urandom_range(99) < 15) ? frames.start_val : 8'($urandom_range(255)));
    end else if (sel < 85) begin
      if ($urandom_range(1)) drive_item(CMD_READ, 8'($urandom_range(255)), pick_read_index());
      else drive_item(CMD_RELEASE, 8'($urandom_range(255)), 9'($urandom_range(511)));
    end else if (sel < 93) begin
      // frame cut short; later bytes land wherever the parser stands
      send_byte(frames.start_val);
      send_byte(pick_addr(frames.src_lo, frames.src_hi));
      send_byte(pick_addr(frames.dst_lo, frames.dst_hi));
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
    end else if ($urandom_range(1)) begin
      drive_item(CMD_UNUSED, 8'($urandom_range(255)), 9'($urandom_range(511)));
    end else begin
      // start byte as source: restarts when it is outside the source range
      send_byte(frames.start_val);
      send_byte(frames.start_val);
    end
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drive_item(CMD_READ, 8'h00, 9'd511);
    drive_item(CMD_RELEASE, 8'hFF, 9'd0);
    drive_item(CMD_UNUSED, 8'h5A, 9'd256);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 8'd0, 8'd0, 1'b1);
    drive_item(CMD_READ, 8'h00, 9'd0);
    drive_item(CMD_READ, 8'hFF, 9'd3);
    send_byte(START_RESET);    // unread packet dropped
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(START_RESET);    // schema length too big, and it is a start byte
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'd33);          // schema length too big
    send_frame(8'h12, 8'h34, 8'd1, 8'd1, 1'b0);
    send_frame(8'hA5, 8'h5A, 8'd2, 8'd1, 1'b1);
    drive_item(CMD_RELEASE, 8'h00, 9'd0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: configure(8'h7E, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        1: configure(8'h00, 16'h0000, 8'h10, 8'hE0, 8'h05, 8'hFA);
        2: configure(8'hFF, 16'h1D0F, 8'h40, 8'h40, 8'h00, 8'h7F);
        3: configure(8'($urandom_range(255)), 16'($urandom_range(65535)),
                     8'h80, 8'h7F, 8'h00, 8'hFF);
        4: configure(8'($urandom_range(255)), 16'($urandom_range(65535)),
                     8'($urandom_range(100)), 8'($urandom_range(255, 150)),
                     8'($urandom_range(100)), 8'($urandom_range(255, 150)));
        default: configure(8'h7E, 16'hFFFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
      endcase
      if (p < 2) begin
        send_idle = 31;
        recv_idle = 56;
      end else if (p < 4) begin
        send_idle = 56;
        recv_idle = 31;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_action();
    end

    s_tvalid <= 1'b0;
    while (frames.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (frames.pending_results.size() != 0)
      frames.report_mismatch("results never seen", 48'(frames.pending_results.size()), 48'(0));
    if (frames.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lfpr_pkg.sv
rtl/core/length_framed_packet_receiver_crc16.sv
tb/sv/tb_top.sv
